// File: hw/rtl/watchpoint_slot_table_macros.svh
// ----------------------------------------------------------------------------
// Watchpoint slot table assertion macros
// Short forms for the concurrent checks of the slot table top level.
// ----------------------------------------------------------------------------
`ifndef WATCHPOINT_SLOT_TABLE_MACROS_SVH
`define WATCHPOINT_SLOT_TABLE_MACROS_SVH

// A condition that must hold at every clock edge out of reset.
`define WST_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define WST_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its trigger.
`define WST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/wst_pkg.sv
// ----------------------------------------------------------------------------
// Watchpoint slot table package
// Sizes, request codes, flag bits and the packet that walks the slot chain.
// ----------------------------------------------------------------------------
package wst_pkg;

    // Table size and derived widths.
    localparam int SLOTS  = 4;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int NSTAT  = 5;

    // Request codes, also used as the operation of a chain packet.
    localparam logic [2:0] REQ_CLAIM    = 3'd0;
    localparam logic [2:0] REQ_RELEASE  = 3'd1;
    localparam logic [2:0] REQ_TRIP     = 3'd2;
    localparam logic [2:0] REQ_ROTATE   = 3'd3;
    localparam logic [2:0] REQ_CLEAR    = 3'd4;
    localparam logic [2:0] REQ_READ     = 3'd5;
    localparam logic [2:0] REQ_OCCUPIED = 3'd6;
    localparam logic [2:0] REQ_STATS    = 3'd7;

    // Slot flag values and bit positions.
    localparam logic [2:0] FLAG_OCC     = 3'b001;
    localparam logic [2:0] FLAG_REL     = 3'b010;
    localparam logic [2:0] FLAG_TRIP    = 3'b100;
    localparam int         FLAG_REL_BIT = 1;

    // Statistics counter numbers.
    localparam int STAT_CLAIMS    = 0;
    localparam int STAT_DROPS     = 1;
    localparam int STAT_RELEASES  = 2;
    localparam int STAT_TRIPS     = 3;
    localparam int STAT_ROTATIONS = 4;

    // Contents of one slot; also the read data carried back by a packet.
    typedef struct packed {
        logic [63:0] address;
        logic [63:0] value;
        logic [63:0] alloc_site;
        logic [63:0] armed_tick;
        logic [63:0] free_tick;
        logic [31:0] generation;
        logic [2:0]  flags;
        logic [31:0] thread;
        logic        was_code;
    } t_slot;

    // Packet that passes from cell to cell, one cell per cycle.
    typedef struct packed {
        logic              vld;
        logic [2:0]        op;
        logic [63:0]       address;
        logic [63:0]       value;
        logic              was_code;
        logic [63:0]       alloc_site;
        logic [63:0]       tick;
        logic [31:0]       generation;
        logic [31:0]       thread;
        logic [7:0]        idx;
        logic [SLOT_W-1:0] pos;
        logic              done;
        logic [SLOT_W-1:0] hit;
        logic [CNT_W-1:0]  cnt;
        logic              min_vld;
        logic [63:0]       min_tick;
        logic [63:0]       min_addr;
        t_slot             rd;
    } t_pkt;

endpackage

// File: hw/rtl/watchpoint_slot_table.sv
// ----------------------------------------------------------------------------
// Watchpoint slot table
// Top level: controller plus a chain of slot cells, one cell per watch slot.
// ----------------------------------------------------------------------------
// Each request is served by a packet that walks the row of slot cells, one
// cell per clock, from the launch register through every cell and back to
// the controller. A rotate that releases a slot walks the row twice, once to
// find the oldest live slot and once to release it; a rotate that finds
// nothing to release walks it once. Stats requests and requests rejected on
// their fields alone (zero address, slot index out of range) skip the row and
// are answered by the controller. One request is in the table at a time; a
// finished result waits in its output register while the next request is
// taken. max_hold_ticks may be written at any time the table is idle and takes
// effect from the next rotate.

`include "watchpoint_slot_table_macros.svh"

module watchpoint_slot_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_address,
    input  logic [63:0] i_value_at_arm,
    input  logic        i_armed_was_code,
    input  logic [63:0] i_alloc_site,
    input  logic [63:0] i_tick,
    input  logic [31:0] i_generation,
    input  logic [31:0] i_thread_id,
    input  logic [7:0]  i_slot_index,
    // Configuration
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_ok,
    output logic [1:0]  o_slot_out,
    output logic [31:0] o_result_count,
    output logic [63:0] o_rd_address,
    output logic [63:0] o_rd_value,
    output logic [63:0] o_rd_alloc_site,
    output logic [63:0] o_rd_armed_tick,
    output logic [63:0] o_rd_free_tick,
    output logic [31:0] o_rd_generation,
    output logic [2:0]  o_rd_flags,
    output logic [31:0] o_rd_thread_id,
    output logic        o_rd_was_code
);

    wst_pkg::t_pkt           w_pkt [wst_pkg::SLOTS + 1];
    wst_pkg::t_slot          w_rd;
    logic [wst_pkg::SLOTS:0] w_in_flight;

    // Controller: request intake, packet launch, counters and result hold.
    wst_ctl u_ctl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_req_type       (i_req_type),
        .i_address        (i_address),
        .i_value_at_arm   (i_value_at_arm),
        .i_armed_was_code (i_armed_was_code),
        .i_alloc_site     (i_alloc_site),
        .i_tick           (i_tick),
        .i_generation     (i_generation),
        .i_thread_id      (i_thread_id),
        .i_slot_index     (i_slot_index),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_launch         (w_pkt[0]),
        .i_ret            (w_pkt[wst_pkg::SLOTS]),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_ok             (o_ok),
        .o_slot_out       (o_slot_out),
        .o_result_count   (o_result_count),
        .o_rd             (w_rd)
    );

    // Row of slot cells; the packet moves one cell along each cycle.
    for (genvar g = 0; g < wst_pkg::SLOTS; g++) begin : g_cell
        wst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_pkt   (w_pkt[g]),
            .o_pkt   (w_pkt[g + 1])
        );
    end

    // Read data fields.
    assign o_rd_address    = w_rd.address;
    assign o_rd_value      = w_rd.value;
    assign o_rd_alloc_site = w_rd.alloc_site;
    assign o_rd_armed_tick = w_rd.armed_tick;
    assign o_rd_free_tick  = w_rd.free_tick;
    assign o_rd_generation = w_rd.generation;
    assign o_rd_flags      = w_rd.flags;
    assign o_rd_thread_id  = w_rd.thread;
    assign o_rd_was_code   = w_rd.was_code;

    // Valid bits of every packet stage, for the checks below.
    for (genvar g = 0; g <= wst_pkg::SLOTS; g++) begin : g_vld
        assign w_in_flight[g] = w_pkt[g].vld;
    end

    // At most one packet is ever in the chain.
    `WST_ASSERT_ALWAYS(a_one_in_flight, $countones(w_in_flight) <= 1, "two packets in chain")
    // No request is taken while a packet is still in the chain.
    `WST_ASSERT_IMPLIES(a_busy_not_ready, w_in_flight != '0, !o_ready, "ready while busy")
    // Taking a request closes the intake for at least the following cycle.
    `WST_ASSERT_NEXT(a_accept_closes, i_valid && o_ready, !o_ready, "ready after accept")

endmodule

// File: hw/rtl/wst_cell.sv
// ----------------------------------------------------------------------------
// Watchpoint slot cell
// Holds one slot, applies the passing request to it and forwards the packet.
// ----------------------------------------------------------------------------
module wst_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  wst_pkg::t_pkt i_pkt,
    output wst_pkg::t_pkt o_pkt
);

    wst_pkg::t_slot r_slot;
    wst_pkg::t_slot n_slot;
    wst_pkg::t_pkt  r_pkt;
    wst_pkg::t_pkt  n_pkt;
    logic           w_live;
    logic           w_here;

    // A slot is live when it holds an address and has not been released.
    assign w_live = (r_slot.address != 64'd0) && !r_slot.flags[wst_pkg::FLAG_REL_BIT];
    assign w_here = (8'(i_pkt.pos) == i_pkt.idx);

    // Apply the request to this slot and update the carried results.
    always_comb begin
        n_slot     = r_slot;
        n_pkt      = i_pkt;
        n_pkt.pos  = i_pkt.pos + wst_pkg::SLOT_W'(1);
        if (i_pkt.vld) begin
            unique case (i_pkt.op)
                wst_pkg::REQ_CLAIM: begin
                    if (!i_pkt.done && !w_live) begin
                        n_slot.address    = i_pkt.address;
                        n_slot.value      = i_pkt.value;
                        n_slot.was_code   = i_pkt.was_code;
                        n_slot.alloc_site = i_pkt.alloc_site;
                        n_slot.armed_tick = i_pkt.tick;
                        n_slot.free_tick  = 64'd0;
                        n_slot.generation = i_pkt.generation;
                        n_slot.thread     = i_pkt.thread;
                        n_slot.flags      = wst_pkg::FLAG_OCC;
                        n_pkt.done        = 1'b1;
                        n_pkt.hit         = i_pkt.pos;
                    end
                end
                wst_pkg::REQ_RELEASE: begin
                    if (!i_pkt.done && w_live && (r_slot.address == i_pkt.address)) begin
                        n_slot.flags      = r_slot.flags | wst_pkg::FLAG_REL;
                        n_slot.armed_tick = i_pkt.tick;
                        n_slot.free_tick  = i_pkt.tick;
                        n_pkt.done        = 1'b1;
                    end
                end
                wst_pkg::REQ_TRIP: begin
                    if (w_here) begin
                        n_slot.flags      = r_slot.flags | wst_pkg::FLAG_TRIP;
                        n_slot.armed_tick = i_pkt.tick;
                    end
                end
                wst_pkg::REQ_ROTATE: begin
                    // Strictly smaller keeps the lowest index on a tie.
                    if (w_live && (!i_pkt.min_vld || (r_slot.armed_tick < i_pkt.min_tick))) begin
                        n_pkt.min_vld  = 1'b1;
                        n_pkt.min_tick = r_slot.armed_tick;
                        n_pkt.min_addr = r_slot.address;
                    end
                end
                wst_pkg::REQ_CLEAR: begin
                    if (!r_slot.flags[wst_pkg::FLAG_REL_BIT]) begin
                        if (r_slot.address != 64'd0) begin
                            n_pkt.cnt = i_pkt.cnt + wst_pkg::CNT_W'(1);
                        end
                        n_slot.address    = 64'd0;
                        n_slot.value      = 64'd0;
                        n_slot.was_code   = 1'b0;
                        n_slot.alloc_site = 64'd0;
                        n_slot.flags      = wst_pkg::FLAG_REL;
                        n_slot.armed_tick = i_pkt.tick;
                        n_slot.free_tick  = i_pkt.tick;
                    end
                end
                wst_pkg::REQ_READ: begin
                    if (w_here && (r_slot.address != 64'd0)) begin
                        n_pkt.done = 1'b1;
                        n_pkt.rd   = r_slot;
                    end
                end
                wst_pkg::REQ_OCCUPIED: begin
                    if (w_live) begin
                        n_pkt.cnt = i_pkt.cnt + wst_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Slot storage and the forwarding register towards the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_pkt  <= '0;
        end else begin
            r_slot <= n_slot;
            r_pkt  <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

endmodule

// File: hw/rtl/wst_ctl.sv
// ----------------------------------------------------------------------------
// Watchpoint slot table controller
// Takes requests, launches packets into the cell chain, keeps the statistics
// counters and the hold register, and holds the result for the consumer.
// ----------------------------------------------------------------------------
module wst_ctl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Request channel
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [2:0]                           i_req_type,
    input  logic [63:0]                          i_address,
    input  logic [63:0]                          i_value_at_arm,
    input  logic                                 i_armed_was_code,
    input  logic [63:0]                          i_alloc_site,
    input  logic [63:0]                          i_tick,
    input  logic [31:0]                          i_generation,
    input  logic [31:0]                          i_thread_id,
    input  logic [7:0]                           i_slot_index,
    // Configuration
    input  logic                                 i_cfg_wr_en,
    input  logic [63:0]                          i_cfg_wr_data,
    // Cell chain
    output wst_pkg::t_pkt                        o_launch,
    input  wst_pkg::t_pkt                        i_ret,
    // Result channel
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_ok,
    output logic [1:0]                           o_slot_out,
    output logic [31:0]                          o_result_count,
    output wst_pkg::t_slot                       o_rd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]     r_state, n_state;
    wst_pkg::t_pkt  r_launch, n_launch;
    logic           r_rot, n_rot;
    logic [63:0]    r_max_hold, n_max_hold;
    logic [31:0]    r_stat [wst_pkg::NSTAT];
    logic [31:0]    n_stat [wst_pkg::NSTAT];
    logic           r_res_ok, n_res_ok;
    logic [1:0]     r_res_slot, n_res_slot;
    logic [31:0]    r_res_cnt, n_res_cnt;
    wst_pkg::t_slot r_res_rd, n_res_rd;
    logic           r_out_vld, n_out_vld;
    logic           r_out_ok, n_out_ok;
    logic [1:0]     r_out_slot, n_out_slot;
    logic [31:0]    r_out_cnt, n_out_cnt;
    wst_pkg::t_slot r_out_rd, n_out_rd;

    logic                       w_accept;
    logic [64:0]                w_age;
    logic                       w_rot_go;
    logic [wst_pkg::SLOT_W+1:0] w_hit_ext;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Age of the oldest live slot; the top bit flags a tick below its arm tick.
    assign w_age     = {1'b0, i_ret.tick} - {1'b0, i_ret.min_tick};
    assign w_rot_go  = i_ret.min_vld && !w_age[64] && (w_age[63:0] >= r_max_hold);
    assign w_hit_ext = {2'b00, i_ret.hit};

    // Request sequencing, result capture and counter updates.
    always_comb begin
        n_state    = r_state;
        n_launch   = r_launch;
        n_launch.vld = 1'b0;
        n_rot      = r_rot;
        n_max_hold = r_max_hold;
        n_stat     = r_stat;
        n_res_ok   = r_res_ok;
        n_res_slot = r_res_slot;
        n_res_cnt  = r_res_cnt;
        n_res_rd   = r_res_rd;
        n_out_vld  = r_out_vld;
        n_out_ok   = r_out_ok;
        n_out_slot = r_out_slot;
        n_out_cnt  = r_out_cnt;
        n_out_rd   = r_out_rd;

        if (i_cfg_wr_en) begin
            n_max_hold = i_cfg_wr_data;
        end

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_res_ok   = 1'b0;
                    n_res_slot = 2'd0;
                    n_res_cnt  = 32'd0;
                    n_res_rd   = '0;
                    n_rot      = 1'b0;
                    priority if (i_req_type == wst_pkg::REQ_STATS) begin
                        // Counters are answered here without touching the chain.
                        for (int k = 0; k < wst_pkg::NSTAT; k++) begin
                            if (i_slot_index == 8'(k)) begin
                                n_res_ok  = 1'b1;
                                n_res_cnt = r_stat[k];
                            end
                        end
                        n_state = S_DONE;
                    end else if (((i_req_type == wst_pkg::REQ_CLAIM) ||
                                  (i_req_type == wst_pkg::REQ_RELEASE)) &&
                                 (i_address == 64'd0)) begin
                        n_state = S_DONE;
                    end else if (((i_req_type == wst_pkg::REQ_TRIP) ||
                                  (i_req_type == wst_pkg::REQ_READ)) &&
                                 (i_slot_index >= 8'(wst_pkg::SLOTS))) begin
                        n_state = S_DONE;
                    end else begin
                        n_launch            = '0;
                        n_launch.vld        = 1'b1;
                        n_launch.op         = i_req_type;
                        n_launch.address    = i_address;
                        n_launch.value      = i_value_at_arm;
                        n_launch.was_code   = i_armed_was_code;
                        n_launch.alloc_site = i_alloc_site;
                        n_launch.tick       = i_tick;
                        n_launch.generation = i_generation;
                        n_launch.thread     = i_thread_id;
                        n_launch.idx        = i_slot_index;
                        n_state             = S_BUSY;
                    end
                end
            end
            S_BUSY: begin
                if (i_ret.vld) begin
                    n_state = S_DONE;
                    unique case (i_ret.op)
                        wst_pkg::REQ_CLAIM: begin
                            if (i_ret.done) begin
                                n_res_ok   = 1'b1;
                                n_res_slot = w_hit_ext[1:0];
                                n_stat[wst_pkg::STAT_CLAIMS] =
                                    sat_inc(r_stat[wst_pkg::STAT_CLAIMS]);
                            end else begin
                                n_stat[wst_pkg::STAT_DROPS] =
                                    sat_inc(r_stat[wst_pkg::STAT_DROPS]);
                            end
                        end
                        wst_pkg::REQ_RELEASE: begin
                            if (i_ret.done) begin
                                n_res_ok = 1'b1;
                                n_stat[wst_pkg::STAT_RELEASES] =
                                    sat_inc(r_stat[wst_pkg::STAT_RELEASES]);
                                if (r_rot) begin
                                    n_stat[wst_pkg::STAT_ROTATIONS] =
                                        sat_inc(r_stat[wst_pkg::STAT_ROTATIONS]);
                                end
                            end
                        end
                        wst_pkg::REQ_TRIP: begin
                            n_res_ok = 1'b1;
                            n_stat[wst_pkg::STAT_TRIPS] =
                                sat_inc(r_stat[wst_pkg::STAT_TRIPS]);
                        end
                        wst_pkg::REQ_ROTATE: begin
                            // Second pass releases the oldest slot's address.
                            if (w_rot_go) begin
                                n_launch         = i_ret;
                                n_launch.vld     = 1'b1;
                                n_launch.op      = wst_pkg::REQ_RELEASE;
                                n_launch.address = i_ret.min_addr;
                                n_launch.pos     = '0;
                                n_launch.done    = 1'b0;
                                n_rot            = 1'b1;
                                n_state          = S_BUSY;
                            end
                        end
                        wst_pkg::REQ_CLEAR, wst_pkg::REQ_OCCUPIED: begin
                            n_res_ok  = 1'b1;
                            n_res_cnt = 32'(i_ret.cnt);
                        end
                        wst_pkg::REQ_READ: begin
                            if (i_ret.done) begin
                                n_res_ok = 1'b1;
                                n_res_rd = i_ret.rd;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_ok   = r_res_ok;
                    n_out_slot = r_res_slot;
                    n_out_cnt  = r_res_cnt;
                    n_out_rd   = r_res_rd;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, counters and the hold register are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_launch   <= '0;
            r_rot      <= 1'b0;
            r_max_hold <= 64'd0;
            r_out_vld  <= 1'b0;
            for (int k = 0; k < wst_pkg::NSTAT; k++) begin
                r_stat[k] <= 32'd0;
            end
        end else begin
            r_state    <= n_state;
            r_launch   <= n_launch;
            r_rot      <= n_rot;
            r_max_hold <= n_max_hold;
            r_out_vld  <= n_out_vld;
            r_stat     <= n_stat;
        end
    end

    // Result payload registers.
    always_ff @(posedge i_clk) begin
        r_res_ok   <= n_res_ok;
        r_res_slot <= n_res_slot;
        r_res_cnt  <= n_res_cnt;
        r_res_rd   <= n_res_rd;
        r_out_ok   <= n_out_ok;
        r_out_slot <= n_out_slot;
        r_out_cnt  <= n_out_cnt;
        r_out_rd   <= n_out_rd;
    end

    assign o_launch       = r_launch;
    assign o_valid        = r_out_vld;
    assign o_ok           = r_out_ok;
    assign o_slot_out     = r_out_slot;
    assign o_result_count = r_out_cnt;
    assign o_rd           = r_out_rd;

endmodule
